// File: rtl/gcc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the graph connectivity checker.
// Depends on nothing; every other file of the block but gcc_ram imports it.
package gcc_pkg;

    // Default number of vertices the graph can hold.
    localparam int VERTEX_LIMIT_DEF = 64;

    // Width of the vertex count field of a result item.
    localparam int CNT_W = 7;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } gcc_op_t;

    typedef struct packed {
        gcc_op_t    op;
        logic [7:0] vertex_a;
        logic [7:0] vertex_b;
    } gcc_req_t;

    typedef struct packed {
        logic             connected;
        logic             rejected;
        logic [CNT_W-1:0] vertex_count;
    } gcc_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD_A,
        S_ADD_WR_A,
        S_ADD_WR_B,
        S_Q_PICK,
        S_Q_MERGE,
        S_FINISH
    } gcc_state_t;

    // Source of the adjacency row read address.
    typedef enum logic [1:0] {
        RD_A = 2'd0,
        RD_B = 2'd1,
        RD_V = 2'd2
    } gcc_rd_src_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic    req_valid;
        gcc_op_t op;
        logic    add_ok;
        logic    count_zero;
        logic    pending_zero;
        logic    rsp_free;
    } gcc_stat_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic        accept;
        logic        bump;
        logic        clear_graph;
        logic        res_load;
        logic        res_conn;
        logic        res_rej;
        logic        q_init;
        logic        q_pick;
        logic        q_merge;
        logic        q_done;
        gcc_rd_src_t rd_src;
        logic        ram_we;
        logic        wr_b;
        logic        rsp_load;
    } gcc_ctrl_t;

endpackage

// File: rtl/gcc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; a read of the address being written returns the old word.
module gcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/gcc_lowbit.sv
`timescale 1ns / 1ps
// Lowest-set-bit unit: isolates the lowest one of a word with a single
// wide add and encodes its position. Uses gcc_pkg for the default width.
module gcc_lowbit
    import gcc_pkg::*;
#(
    parameter int W = VERTEX_LIMIT_DEF
)(
    input  logic [W-1:0]         vec,
    output logic [W-1:0]         onehot,
    output logic [$clog2(W)-1:0] index
);

    localparam int IW = $clog2(W);

    always_comb
    begin
        onehot = vec & (~vec + W'(1));
        for (int k = 0; k < IW; k++)
        begin
            index[k] = 1'b0;
            for (int i = 0; i < W; i++)
            begin
                if (((i >> k) & 1) == 1)
                begin
                    index[k] = index[k] | onehot[i];
                end
            end
        end
    end

endmodule

// File: rtl/gcc_seq.sv
`timescale 1ns / 1ps
// Sequencer of the graph connectivity checker: decodes each item and steps
// the adjacency RAM and the lowest-bit unit through it. Uses gcc_pkg.
module gcc_seq
    import gcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  gcc_stat_t stat,
    output gcc_ctrl_t ctrl,
    output logic      req_ready
);

    gcc_state_t state_reg;
    gcc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (stat.req_valid)
                begin
                    ctrl.accept   = 1'b1;
                    ctrl.res_load = 1'b1;
                    unique case (stat.op)
                        OP_ADD:
                        begin
                            if (stat.add_ok)
                            begin
                                ctrl.bump  = 1'b1;
                                state_next = S_ADD_RD_A;
                            end
                            else
                            begin
                                ctrl.res_rej = 1'b1;
                                state_next   = S_FINISH;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (stat.count_zero)
                            begin
                                ctrl.res_conn = 1'b1;
                                state_next    = S_FINISH;
                            end
                            else
                            begin
                                ctrl.q_init = 1'b1;
                                state_next  = S_Q_PICK;
                            end
                        end
                        OP_CLEAR:
                        begin
                            ctrl.clear_graph = 1'b1;
                            state_next       = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_ADD_RD_A:
            begin
                ctrl.rd_src = RD_A;
                state_next  = S_ADD_WR_A;
            end
            S_ADD_WR_A:
            begin
                ctrl.ram_we = 1'b1;
                ctrl.wr_b   = 1'b0;
                ctrl.rd_src = RD_B;
                state_next  = S_ADD_WR_B;
            end
            S_ADD_WR_B:
            begin
                ctrl.ram_we = 1'b1;
                ctrl.wr_b   = 1'b1;
                state_next  = S_FINISH;
            end
            S_Q_PICK:
            begin
                if (stat.pending_zero)
                begin
                    ctrl.q_done = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    ctrl.q_pick = 1'b1;
                    ctrl.rd_src = RD_V;
                    state_next  = S_Q_MERGE;
                end
            end
            S_Q_MERGE:
            begin
                ctrl.q_merge = 1'b1;
                state_next   = S_Q_PICK;
            end
            S_FINISH:
            begin
                if (stat.rsp_free)
                begin
                    ctrl.rsp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/graph_connectivity_checker_unit.sv
`timescale 1ns / 1ps
// Top level of the graph connectivity checker: adjacency RAM, walk state,
// vertex count and result register. Uses gcc_pkg, gcc_ram, gcc_lowbit, gcc_seq.
//
//   channel   signals                      carries
//   -------   --------------------------   -----------------------------------
//   request   req_valid, req_ready, req    op, vertex_a, vertex_b
//   response  rsp_valid, rsp_ready, rsp    connected, rejected, vertex_count
//
// An add-edge item does one read-modify-write of each of its two rows through
// the single RAM port pair before the next item can be accepted.
// A query expands each vertex reached from vertex 0 with one pick in
// the lowest-bit unit and one row read.
// Clear, rejected adds, unused op codes and empty-graph queries skip the RAM.
// Reset empties the graph at once through per-row valid bits; no sweep runs.
// A finished result waits in the response register while the next item is
// taken; only a result that finds that register still full stalls the block.

module graph_connectivity_checker_unit
    import gcc_pkg::*;
#(
    parameter int VERTEX_LIMIT = VERTEX_LIMIT_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  gcc_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output gcc_rsp_t rsp
);

    localparam int AW = $clog2(VERTEX_LIMIT);

    typedef logic [VERTEX_LIMIT-1:0] row_t;

    gcc_ctrl_t        ctrl;
    gcc_stat_t        stat;

    // Latched endpoints of the current item.
    logic [7:0]       a_reg;
    logic [7:0]       b_reg;

    // Graph state. A row whose valid bit is low reads as all zeros.
    logic [CNT_W-1:0] count_reg;
    row_t             valid_reg;

    // Walk state of a query: vertices waiting to be expanded and vertices
    // already expanded. The two sets never overlap.
    row_t             pending_reg;
    row_t             reached_reg;

    // Result flags of the current item and the response register.
    logic             conn_reg;
    logic             rej_reg;
    logic             rsp_valid_reg;
    gcc_rsp_t         rsp_reg;

    // Valid bit of the row whose read is in flight.
    logic             rd_valid_reg;

    logic             add_ok;
    logic [7:0]       max_end;
    logic [CNT_W-1:0] top_count;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    row_t             wr_data;
    row_t             ram_q;
    row_t             row_q;
    row_t             low_onehot;
    logic [AW-1:0]    low_idx;
    row_t             need;
    row_t             bit_a;
    row_t             bit_b;

    // An edge is stored only when both endpoints lie below the vertex limit;
    // the count then rises to the larger endpoint plus one.
    assign add_ok    = (req.vertex_a < 8'(VERTEX_LIMIT)) && (req.vertex_b < 8'(VERTEX_LIMIT));
    assign max_end   = (req.vertex_a > req.vertex_b) ? req.vertex_a : req.vertex_b;
    assign top_count = max_end[CNT_W-1:0] + CNT_W'(1);

    assign bit_a = row_t'(1) << a_reg[AW-1:0];
    assign bit_b = row_t'(1) << b_reg[AW-1:0];
    assign row_q = rd_valid_reg ? ram_q : '0;

    always_comb
    begin
        case (ctrl.rd_src)
            RD_A:    rd_addr = a_reg[AW-1:0];
            RD_B:    rd_addr = b_reg[AW-1:0];
            default: rd_addr = low_idx;
        endcase
    end

    // Row a gets bit b, then row b gets bit a. For a self-loop both writes
    // carry the same word, so the second read seeing the old row is harmless.
    assign wr_addr = ctrl.wr_b ? b_reg[AW-1:0] : a_reg[AW-1:0];
    assign wr_data = ctrl.wr_b ? (row_q | bit_a) : (row_q | bit_b);

    // Vertices that must be reached for the graph to count as connected.
    always_comb
    begin
        for (int i = 0; i < VERTEX_LIMIT; i++)
        begin
            need[i] = (CNT_W'(i) < count_reg);
        end
    end

    always_comb
    begin
        stat              = '0;
        stat.req_valid    = req_valid;
        stat.op           = req.op;
        stat.add_ok       = add_ok;
        stat.count_zero   = (count_reg == '0);
        stat.pending_zero = (pending_reg == '0);
        stat.rsp_free     = !rsp_valid_reg || rsp_ready;
    end

    gcc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .ctrl      (ctrl),
        .req_ready (req_ready)
    );

    gcc_ram #(
        .WIDTH (VERTEX_LIMIT),
        .DEPTH (VERTEX_LIMIT)
    ) u_adj_ram (
        .clk   (clk),
        .we    (ctrl.ram_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // The next vertex to expand is the lowest pending one.
    gcc_lowbit #(
        .W (VERTEX_LIMIT)
    ) u_lowbit (
        .vec    (pending_reg),
        .onehot (low_onehot),
        .index  (low_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            valid_reg     <= '0;
            pending_reg   <= '0;
            reached_reg   <= '0;
            conn_reg      <= 1'b0;
            rej_reg       <= 1'b0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];

            if (ctrl.clear_graph)
            begin
                count_reg <= '0;
                valid_reg <= '0;
            end
            else
            begin
                if (ctrl.bump && (top_count > count_reg))
                begin
                    count_reg <= top_count;
                end
                if (ctrl.ram_we)
                begin
                    valid_reg[wr_addr] <= 1'b1;
                end
            end

            if (ctrl.q_init)
            begin
                pending_reg <= row_t'(1);
                reached_reg <= '0;
            end
            else if (ctrl.q_pick)
            begin
                pending_reg <= pending_reg & ~low_onehot;
                reached_reg <= reached_reg | low_onehot;
            end
            else if (ctrl.q_merge)
            begin
                pending_reg <= pending_reg | (row_q & ~reached_reg);
            end

            if (ctrl.res_load)
            begin
                conn_reg <= ctrl.res_conn;
                rej_reg  <= ctrl.res_rej;
            end
            else if (ctrl.q_done)
            begin
                conn_reg <= &(reached_reg | ~need);
            end

            if (ctrl.rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            a_reg <= req.vertex_a;
            b_reg <= req.vertex_b;
        end
        if (ctrl.rsp_load)
        begin
            rsp_reg.connected    <= conn_reg;
            rsp_reg.rejected     <= rej_reg;
            rsp_reg.vertex_count <= count_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The vertex count never passes the vertex limit.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(VERTEX_LIMIT))
        else $error("vertex count above vertex limit");

    // The walk never holds a vertex as both pending and reached.
    a_walk_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & reached_reg) == '0)
        else $error("vertex both pending and reached");

    // A result never reports a rejected edge and a connected graph at once.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.connected && rsp.rejected))
        else $error("connected and rejected both set");

    // A clear item empties the graph in the following cycle.
    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.op == OP_CLEAR)) |=>
            (count_reg == '0) && (valid_reg == '0))
        else $error("clear item left graph state behind");

endmodule

// File: test/graph_result_checker.sv
`timescale 1ns / 1ps
// Response checker for the graph connectivity checker: keeps its own copy of
// the adjacency matrix and vertex count, predicts every response and compares.
// Depends on gcc_pkg for the item types and the operation codes.
module graph_result_checker
    import gcc_pkg::*;
#(
    parameter int VERTEX_LIMIT = VERTEX_LIMIT_DEF
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  gcc_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  gcc_rsp_t rsp,
    output int       failures,
    output int       outstanding
);

    logic [63:0]      adj_rows [VERTEX_LIMIT];
    logic [CNT_W-1:0] vertex_total;
    gcc_rsp_t         predicted_rsps [$];
    gcc_rsp_t         want;

    // Grows the reached set from vertex 0 until it stops changing.
    function automatic logic all_reached();
        logic [63:0] seen;
        logic [63:0] grown;
        logic [63:0] need;
        logic        changed;
        int          v;
        if (vertex_total == 0)
            return 1'b1;
        seen = 64'd1;
        changed = 1'b1;
        while (changed)
        begin
            grown = seen;
            for (v = 0; v < VERTEX_LIMIT; v++)
                if (seen[v])
                    grown |= adj_rows[v];
            changed = (grown != seen);
            seen = grown;
        end
        need = (vertex_total >= 64) ? '1 : (64'd1 << vertex_total) - 64'd1;
        return (seen & need) == need;
    endfunction

    function automatic gcc_rsp_t apply_item(gcc_req_t item);
        gcc_rsp_t   result;
        logic [7:0] top;
        int         i;
        result = '0;
        case (item.op)
            OP_ADD:
            begin
                if (item.vertex_a < VERTEX_LIMIT && item.vertex_b < VERTEX_LIMIT)
                begin
                    adj_rows[item.vertex_a][item.vertex_b] = 1'b1;
                    adj_rows[item.vertex_b][item.vertex_a] = 1'b1;
                    top = ((item.vertex_a > item.vertex_b) ? item.vertex_a
                                                           : item.vertex_b) + 8'd1;
                    if (top > vertex_total)
                        vertex_total = top[CNT_W-1:0];
                end
                else
                begin
                    result.rejected = 1'b1;
                end
            end
            OP_QUERY:
                result.connected = all_reached();
            OP_CLEAR:
            begin
                for (i = 0; i < VERTEX_LIMIT; i++)
                    adj_rows[i] = '0;
                vertex_total = '0;
            end
            default:
                ;
        endcase
        result.vertex_count = vertex_total;
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VERTEX_LIMIT; i++)
                adj_rows[i] = '0;
            vertex_total = '0;
            predicted_rsps.delete();
            failures = 0;
            outstanding = 0;
        end
        else
        begin
            // A response always belongs to an older item, so it is matched
            // before this edge's item is added to the queue.
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_rsps.size() == 0)
                begin
                    failures++;
                    $display("%0t: response with nothing pending: %p", $time, rsp);
                end
                else
                begin
                    want = predicted_rsps.pop_front();
                    if (rsp.connected !== want.connected)
                    begin
                        failures++;
                        $display("%0t: connected expected %0b actual %0b",
                                 $time, want.connected, rsp.connected);
                    end
                    if (rsp.rejected !== want.rejected)
                    begin
                        failures++;
                        $display("%0t: rejected expected %0b actual %0b",
                                 $time, want.rejected, rsp.rejected);
                    end
                    if (rsp.vertex_count !== want.vertex_count)
                    begin
                        failures++;
                        $display("%0t: vertex_count expected %0d actual %0d",
                                 $time, want.vertex_count, rsp.vertex_count);
                    end
                end
            end
            if (req_valid && req_ready)
                predicted_rsps.push_back(apply_item(req));
            outstanding = predicted_rsps.size();
        end
    end

endmodule

// File: test/graph_connectivity_checker_unit_test.sv
`timescale 1ns / 1ps
// Top of the graph connectivity checker testbench: clock, reset, item stimulus
// and the verdict. Depends on gcc_pkg, the block, and graph_result_checker.
module graph_connectivity_checker_unit_test;
    import gcc_pkg::*;

    localparam int VERTEX_LIMIT = VERTEX_LIMIT_DEF;
    // The slowest item is a query that reaches all vertices, so even a run
    // made only of such items stays far below this.
    localparam int CYCLE_LIMIT = 800000;
    // Quiet cycles after the last response, to catch any stray extra one.
    localparam int DRAIN_CYCLES = 150;
    localparam int ITEM_TARGET = 1850;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    gcc_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    gcc_rsp_t rsp;

    int       failures;
    int       outstanding;
    int       cycle_count = 0;
    int       items_sent = 0;
    // While set, neither side idles, so the block runs back to back.
    logic     steady = 1'b0;

    graph_connectivity_checker_unit #(
        .VERTEX_LIMIT(VERTEX_LIMIT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    graph_result_checker #(
        .VERTEX_LIMIT(VERTEX_LIMIT)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The response side stalls in about a quarter of the cycles, except
    // during the steady stretch.
    always @(posedge clk)
    begin
        if (steady)
            rsp_ready <= 1'b1;
        else
            rsp_ready <= ($urandom_range(0, 99) >= 26);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[graph_connectivity_checker_unit] ERROR");
            $finish;
        end
    end

    // Presents one item and holds it until the block takes it. Valid stays
    // high into the next item unless an idle gap is drawn, so it is never
    // lowered and raised within the same time step.
    task automatic send_item(input gcc_op_t op, input int a, input int b);
        gcc_req_t item;
        item.op = op;
        item.vertex_a = a[7:0];
        item.vertex_b = b[7:0];
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
        steady = (items_sent >= 700 && items_sent < 1000);
        if (!steady && $urandom_range(0, 99) < 26)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
    endtask

    // The graph is undirected, so the endpoint order is drawn at random.
    task automatic send_link(input int x, input int y);
        if ($urandom_range(0, 1))
            send_item(OP_ADD, x, y);
        else
            send_item(OP_ADD, y, x);
    endtask

    // Occasionally slips a query, a bad edge, an unused op code or a random
    // edge among the well-formed edges, so that every item kind lands on
    // graphs at every stage of construction.
    task automatic mix_in_noise(input int n);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            send_item(OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 255));
        else if (pick < 17)
            send_link($urandom_range(VERTEX_LIMIT, 255), $urandom_range(0, 255));
        else if (pick < 20)
            send_item(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255));
        else if (pick < 26)
            send_link($urandom_range(0, n - 1), $urandom_range(0, n - 1));
    endtask

    // One random graph. Each new vertex usually hangs off an earlier one, so
    // most graphs come out connected; a skipped edge or a lone self-loop
    // leaves a vertex cut off. Most graphs are small, a few fill all vertices.
    task automatic build_graph();
        int n;
        int v;
        int k;
        n = ($urandom_range(0, 11) == 0) ? VERTEX_LIMIT : $urandom_range(1, 16);
        for (v = 1; v < n; v++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_item(OP_ADD, v, v);
            else if ($urandom_range(0, 29) != 0)
                send_link(v, $urandom_range(0, v - 1));
            mix_in_noise(n);
        end
        for (k = $urandom_range(0, n / 2); k > 0; k--)
            send_link($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        send_item(OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 255));
        // Now and then the graph is kept, and the next one grows on top of it.
        if ($urandom_range(0, 6) != 0)
            send_item(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty graph reads as connected.
        send_item(OP_QUERY, 0, 0);
        // A self-loop on vertex 0 alone gives a one-vertex connected graph.
        send_item(OP_ADD, 0, 0);
        send_item(OP_QUERY, 255, 255);
        send_item(OP_CLEAR, 255, 255);
        // A self-loop on a new vertex raises the count but joins nothing.
        send_item(OP_ADD, 5, 5);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_ADD, 0, 1);
        // The same edge again, both ways round, changes nothing.
        send_item(OP_ADD, 1, 0);
        send_item(OP_ADD, 0, 1);
        // Endpoints at or above the limit are refused, either side.
        send_item(OP_ADD, VERTEX_LIMIT, 0);
        send_item(OP_ADD, 0, VERTEX_LIMIT);
        send_item(OP_ADD, 255, 255);
        send_item(OP_ADD, 0, 255);
        // The highest vertex takes the count to its maximum.
        send_item(OP_ADD, VERTEX_LIMIT - 1, 2);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_NONE, 255, 255);
        send_item(OP_NONE, 0, 0);
        send_item(OP_ADD, 1, 2);
        send_item(OP_ADD, 5, VERTEX_LIMIT - 1);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_CLEAR, 0, 0);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_ADD, VERTEX_LIMIT - 1, VERTEX_LIMIT - 1);
        send_item(OP_QUERY, 0, 0);
        send_item(OP_CLEAR, 0, 0);

        // Random part.
        while (items_sent < ITEM_TARGET)
            build_graph();

        // Waiting for the clock lets the checker record the last accepted
        // item before its pending count is read.
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (failures == 0)
            $display("[graph_connectivity_checker_unit] OK");
        else
            $display("[graph_connectivity_checker_unit] ERROR");
        $finish;
    end

endmodule
